// ----- design/syrpn_pkg.sv -----
package syrpn_pkg;

  // token kinds
  localparam logic [3:0] K_NUMBER  = 4'd0;
  localparam logic [3:0] K_STRING  = 4'd1;
  localparam logic [3:0] K_LOOKUP  = 4'd2;
  localparam logic [3:0] K_FSTART  = 4'd3;
  localparam logic [3:0] K_ISTART  = 4'd4;
  localparam logic [3:0] K_ASTART  = 4'd5;
  localparam logic [3:0] K_ARGEND  = 4'd6;
  localparam logic [3:0] K_ELEMEND = 4'd7;
  localparam logic [3:0] K_FEND    = 4'd8;
  localparam logic [3:0] K_AEND    = 4'd9;
  localparam logic [3:0] K_IEND    = 4'd10;
  localparam logic [3:0] K_OPER    = 4'd11;

  // result status
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_COMMA     = 4'd1;
  localparam logic [3:0] ST_PAREN     = 4'd2;
  localparam logic [3:0] ST_FEND      = 4'd3;
  localparam logic [3:0] ST_AEND      = 4'd4;
  localparam logic [3:0] ST_IEND      = 4'd5;
  localparam logic [3:0] ST_EXP_OPER  = 4'd6;
  localparam logic [3:0] ST_EXTRA_PAR = 4'd7;
  localparam logic [3:0] ST_OVERFLOW  = 4'd8;

  // config register indexes
  localparam logic CFG_OPEN_PAREN  = 1'b0;
  localparam logic CFG_CLOSE_PAREN = 1'b1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  op;
    logic [7:0]  prec;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PUSH,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    M_FLUSH,
    M_POPTO,
    M_CLOSE,
    M_OPER
  } mode_t;

  typedef enum logic [2:0] {
    A_EMIT,
    A_EMIT_PUSH,
    A_PUSH,
    A_FIN,
    A_DROP,
    A_ERR
  } act_t;

endpackage

// ----- design/syrpn_ram.sv -----
module syrpn_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/shunting_yard_rpn_converter_unit.sv -----
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    func token_kind operator_code precedence right_assoc token_tag
// out       out  out_valid/out_ready  has_token out_tag out_kind out_operator status last
// cfg       in   cfg_write            cfg_index cfg_data (no wait, no read-back)
//
// Operand: accept, then finish. Push: accept, push, finish. Closers, operators and flush:
// read and evaluate each stack entry visited, then finish, with a further read when the
// stack is found empty; an operator adds a push step; an error after a token adds a result.
// The pop loop is bound by the single registered read port of the stack RAM.
// Reset clears the stack count and sets the config to open code 0, close code 1; the stack RAM is not cleared.
// A stalled output holds the sequencer only where it must emit; in_ready is high only when idle.
module shunting_yard_rpn_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [3:0]  token_kind,
  input  logic [7:0]  operator_code,
  input  logic [7:0]  precedence,
  input  logic        right_assoc,
  input  logic [15:0] token_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_token,
  output logic [15:0] out_tag,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_operator,
  output logic [3:0]  status,
  output logic        last
);
  import syrpn_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EW = $bits(entry_t);

  state_t      state, state_next;
  mode_t       mode, mode_next;
  logic [3:0]  stop_kind, stop_kind_next;
  logic [3:0]  empty_err, empty_err_next;
  logic [3:0]  fin_status, fin_status_next;
  logic [CW-1:0] cnt, cnt_next;
  logic        pend_valid, pend_valid_next;
  entry_t      pend, pend_next;
  entry_t      tok, tok_next;
  logic        tok_rassoc, tok_rassoc_next;
  logic [7:0]  open_code, close_code;

  logic        out_valid_next, has_token_next, last_next;
  logic [15:0] out_tag_next;
  logic [3:0]  out_kind_next, status_next;
  logic [7:0]  out_operator_next;

  logic          ram_we, ram_re;
  logic [EW-1:0] ram_rdata;
  entry_t        top;
  logic [CW-1:0] cnt_m1;
  logic          out_free, full, top_open, pop_it;
  act_t          act;
  logic [3:0]    act_err;

  assign cnt_m1   = cnt - CW'(1);
  assign full     = (cnt == CW'(STACK_DEPTH));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign top      = entry_t'(ram_rdata);
  assign top_open = (top.kind == K_OPER) && (top.op == open_code);
  // precedence compare: incoming precedence against the entry on top
  assign pop_it   = tok_rassoc ? (tok.prec < top.prec) : (tok.prec <= top.prec);

  syrpn_ram #(
    .WIDTH(EW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt[AW-1:0]),
    .wdata(tok),
    .re   (ram_re),
    .raddr(cnt_m1[AW-1:0]),
    .rdata(ram_rdata)
  );

  // what to do with the entry on top
  always_comb begin
    act     = A_EMIT;
    act_err = ST_OK;
    unique case (mode)
      M_FLUSH: begin
        if (top.kind == K_OPER && (top.op == open_code || top.op == close_code)) begin
          act     = A_ERR;
          act_err = ST_EXTRA_PAR;
        end
      end
      M_POPTO: begin
        if (top.kind == stop_kind) act = A_FIN;
      end
      M_CLOSE: begin
        if (top_open) act = A_DROP;
      end
      M_OPER: begin
        if (top.kind == K_LOOKUP) begin
          act = A_EMIT_PUSH;
        end else if (top.kind == K_FSTART || top.kind == K_ISTART ||
                     top.kind == K_ASTART || top_open) begin
          act = A_PUSH;
        end else if (tok.kind != K_OPER || top.kind != K_OPER) begin
          act     = A_ERR;
          act_err = ST_EXP_OPER;
        end else if (!pop_it) begin
          act = A_PUSH;
        end
      end
      default: act = A_EMIT;
    endcase
  end

  always_comb begin
    state_next        = state;
    mode_next         = mode;
    stop_kind_next    = stop_kind;
    empty_err_next    = empty_err;
    fin_status_next   = fin_status;
    cnt_next          = cnt;
    pend_valid_next   = pend_valid;
    pend_next         = pend;
    tok_next          = tok;
    tok_rassoc_next   = tok_rassoc;
    out_valid_next    = out_valid && !out_ready;
    has_token_next    = has_token;
    out_tag_next      = out_tag;
    out_kind_next     = out_kind;
    out_operator_next = out_operator;
    status_next       = status;
    last_next         = last;
    ram_we            = 1'b0;
    ram_re            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          tok_next.kind   = token_kind;
          tok_next.op     = operator_code;
          tok_next.prec   = precedence;
          tok_next.tag    = token_tag;
          tok_rassoc_next = right_assoc;
          fin_status_next = ST_OK;
          mode_next       = M_OPER;
          state_next      = S_READ;
          if (func) begin
            mode_next = M_FLUSH;
          end else begin
            case (token_kind) inside
              K_NUMBER, K_STRING: begin
                pend_next.kind  = token_kind;
                pend_next.op    = operator_code;
                pend_next.prec  = precedence;
                pend_next.tag   = token_tag;
                pend_valid_next = 1'b1;
                state_next      = S_FIN;
              end
              K_LOOKUP, K_FSTART, K_ISTART, K_ASTART: state_next = S_PUSH;
              K_ARGEND: begin
                mode_next      = M_POPTO;
                stop_kind_next = K_FSTART;
                empty_err_next = ST_COMMA;
              end
              K_ELEMEND: begin
                mode_next      = M_POPTO;
                stop_kind_next = K_ASTART;
                empty_err_next = ST_COMMA;
              end
              K_FEND: begin
                mode_next      = M_POPTO;
                stop_kind_next = K_FSTART;
                empty_err_next = ST_FEND;
              end
              K_AEND: begin
                mode_next      = M_POPTO;
                stop_kind_next = K_ASTART;
                empty_err_next = ST_AEND;
              end
              K_IEND: begin
                mode_next      = M_POPTO;
                stop_kind_next = K_ISTART;
                empty_err_next = ST_IEND;
              end
              K_OPER: begin
                // open wins when both codes match
                if (operator_code == open_code) begin
                  state_next = S_PUSH;
                end else if (operator_code == close_code) begin
                  mode_next      = M_CLOSE;
                  empty_err_next = ST_PAREN;
                end
              end
              default: mode_next = M_OPER;
            endcase
          end
        end
      end

      S_READ: begin
        if (cnt == '0) begin
          unique case (mode)
            M_FLUSH: state_next = S_FIN;
            M_OPER:  state_next = S_PUSH;
            default: begin
              fin_status_next = empty_err;
              state_next      = S_FIN;
            end
          endcase
        end else begin
          ram_re     = 1'b1;
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        unique case (act)
          A_EMIT, A_EMIT_PUSH: begin
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                out_valid_next    = 1'b1;
                has_token_next    = 1'b1;
                out_tag_next      = pend.tag;
                out_kind_next     = pend.kind;
                out_operator_next = pend.op;
                status_next       = ST_OK;
                last_next         = 1'b0;
              end
              pend_next       = top;
              pend_valid_next = 1'b1;
              cnt_next        = cnt_m1;
              state_next      = (act == A_EMIT) ? S_READ : S_PUSH;
            end
          end
          A_PUSH: state_next = S_PUSH;
          A_FIN:  state_next = S_FIN;
          A_DROP: begin
            cnt_next   = cnt_m1;
            state_next = S_FIN;
          end
          A_ERR: begin
            cnt_next        = '0;
            fin_status_next = act_err;
            state_next      = S_FIN;
          end
          default: state_next = S_FIN;
        endcase
      end

      S_PUSH: begin
        if (full) begin
          cnt_next        = '0;
          fin_status_next = ST_OVERFLOW;
        end else begin
          ram_we   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
        state_next = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (pend_valid) begin
            // held token goes out; an error result follows it if any
            has_token_next    = 1'b1;
            out_tag_next      = pend.tag;
            out_kind_next     = pend.kind;
            out_operator_next = pend.op;
            status_next       = ST_OK;
            last_next         = (fin_status == ST_OK);
            pend_valid_next   = 1'b0;
            state_next        = (fin_status == ST_OK) ? S_IDLE : S_FIN;
          end else begin
            has_token_next    = 1'b0;
            out_tag_next      = '0;
            out_kind_next     = '0;
            out_operator_next = '0;
            status_next       = fin_status;
            last_next         = 1'b1;
            state_next        = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      open_code  <= 8'd0;
      close_code <= 8'd1;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_OPEN_PAREN:  open_code  <= cfg_data;
          CFG_CLOSE_PAREN: close_code <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode         <= mode_next;
    stop_kind    <= stop_kind_next;
    empty_err    <= empty_err_next;
    fin_status   <= fin_status_next;
    pend         <= pend_next;
    tok          <= tok_next;
    tok_rassoc   <= tok_rassoc_next;
    has_token    <= has_token_next;
    out_tag      <= out_tag_next;
    out_kind     <= out_kind_next;
    out_operator <= out_operator_next;
    status       <= status_next;
    last         <= last_next;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_err_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !has_token && last)
    else $error("error result carries a token or is not final");

  // while idle the result register holds the final result of the last transaction
  a_err_empties: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && out_valid && out_ready && status != ST_OK |-> cnt == '0)
    else $error("stack not empty after error");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_token |-> out_tag == '0 && out_kind == '0 && out_operator == '0)
    else $error("tokenless result has nonzero fields");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> state != S_IDLE)
    else $error("held token left behind at idle");
`endif

endmodule
